// File: rtl/isadma_pkg.sv
// Shared types, port-map constants and decode helpers of the ISA DMA register file.
package isadma_pkg;

    localparam int unsigned NumChan  = 8;
    localparam int unsigned ChanW    = 3;
    localparam int unsigned NumCtl   = 2;

    localparam logic [7:0] PORT_MASK0  = 8'h0A;
    localparam logic [7:0] PORT_MASK1  = 8'hD4;
    localparam logic [7:0] PORT_MODE0  = 8'h0B;
    localparam logic [7:0] PORT_MODE1  = 8'hD6;
    localparam logic [7:0] PORT_CLEAR0 = 8'h0C;
    localparam logic [7:0] PORT_CLEAR1 = 8'hD8;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_READ  = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_WORD  = 3'd1,
        KIND_MASK  = 3'd2,
        KIND_MODE  = 3'd3,
        KIND_CLEAR = 3'd4,
        KIND_PAGE  = 3'd5
    } kind_t;

    typedef struct packed {
        logic             hit;
        logic [ChanW-1:0] chan;
    } page_hit_t;

    function automatic page_hit_t page_lookup(input logic [7:0] port);
        page_hit_t r;
        r.hit  = 1'b1;
        r.chan = '0;
        case (port) inside
            8'h87:   r.chan = 3'd0;
            8'h83:   r.chan = 3'd1;
            8'h81:   r.chan = 3'd2;
            8'h82:   r.chan = 3'd3;
            8'h8F:   r.chan = 3'd4;
            8'h8B:   r.chan = 3'd5;
            8'h89:   r.chan = 3'd6;
            8'h8A:   r.chan = 3'd7;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/isadma_if.sv
// Valid/ready channel interfaces for port accesses and their results.
interface isadma_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] port;
    logic [7:0] wdata;

    modport source (output valid, output action, output port, output wdata, input ready);
    modport sink   (input valid, input action, input port, input wdata, output ready);
endinterface

interface isadma_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rdata;
    logic        decoded;
    logic [2:0]  channel;
    logic [23:0] chan_address;
    logic [15:0] chan_count;
    logic [7:0]  chan_mode;
    logic        chan_masked;
    logic        pointer_high;

    modport source (output valid, output rdata, output decoded, output channel,
                    output chan_address, output chan_count, output chan_mode,
                    output chan_masked, output pointer_high, input ready);
    modport sink   (input valid, input rdata, input decoded, input channel,
                    input chan_address, input chan_count, input chan_mode,
                    input chan_masked, input pointer_high, output ready);
endinterface

// File: rtl/isa_dma_register_file_core.sv
// Register file of two cascaded 8237-style DMA controllers and their page registers.
// Each transfer on req is one I/O port access; it is captured in an input register, decoded
// and applied to the channel registers once the result side can advance, where its result
// also lands in an output register. One access is taken every cycle as long as rsp is
// drained; the rate is set by the single decode-and-update pass between the input register
// and the result register. After reset every channel is masked and both byte pointers
// select the low byte.
module isa_dma_register_file_core (
    input  logic         clk,
    input  logic         rst_n,
    isadma_req_if.sink   req,
    isadma_rsp_if.source rsp
);

    logic       s1_valid_reg;
    logic       s1_action_reg;
    logic [7:0] s1_port_reg;
    logic [7:0] s1_wdata_reg;

    logic [15:0] base_reg   [isadma_pkg::NumChan];
    logic [15:0] count_reg  [isadma_pkg::NumChan];
    logic [7:0]  page_reg   [isadma_pkg::NumChan];
    logic [7:0]  mode_reg   [isadma_pkg::NumChan];
    logic        masked_reg [isadma_pkg::NumChan];
    logic        ptr_reg    [isadma_pkg::NumCtl];

    logic        out_valid_reg;
    logic [7:0]  out_rdata_reg;
    logic        out_decoded_reg;
    logic [2:0]  out_channel_reg;
    logic [23:0] out_address_reg;
    logic [15:0] out_count_reg;
    logic [7:0]  out_mode_reg;
    logic        out_masked_reg;
    logic        out_ptr_reg;

    logic advance;
    logic fire;

    isadma_pkg::kind_t     kind;
    isadma_pkg::page_hit_t page_hit;
    logic [2:0]  ch;
    logic        ctl;
    logic        is_count;
    logic        rd;
    logic        ptr;
    logic [15:0] word_cur;
    logic [15:0] word_new;
    logic [15:0] base_next;
    logic [15:0] count_next;
    logic [7:0]  page_next;
    logic [7:0]  mode_next;
    logic        masked_next;
    logic        ptr_next;
    logic [7:0]  rdata;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    // Capture the access.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_action_reg <= req.action;
            s1_port_reg   <= req.port;
            s1_wdata_reg  <= req.wdata;
        end
    end

    // Decode the port.
    assign page_hit = isadma_pkg::page_lookup(s1_port_reg);

    always_comb
    begin
        kind     = isadma_pkg::KIND_NONE;
        ch       = '0;
        ctl      = 1'b0;
        is_count = 1'b0;
        case (s1_port_reg) inside
            [8'h00:8'h07]:
            begin
                kind     = isadma_pkg::KIND_WORD;
                ch       = {1'b0, s1_port_reg[2:1]};
                is_count = s1_port_reg[0];
            end
            8'hC0, 8'hC2, 8'hC4, 8'hC6, 8'hC8, 8'hCA, 8'hCC, 8'hCE:
            begin
                kind     = isadma_pkg::KIND_WORD;
                ctl      = 1'b1;
                ch       = {1'b1, s1_port_reg[3:2]};
                is_count = s1_port_reg[1];
            end
            isadma_pkg::PORT_MASK0:
            begin
                kind = isadma_pkg::KIND_MASK;
            end
            isadma_pkg::PORT_MASK1:
            begin
                kind = isadma_pkg::KIND_MASK;
                ctl  = 1'b1;
            end
            isadma_pkg::PORT_MODE0:
            begin
                kind = isadma_pkg::KIND_MODE;
            end
            isadma_pkg::PORT_MODE1:
            begin
                kind = isadma_pkg::KIND_MODE;
                ctl  = 1'b1;
            end
            isadma_pkg::PORT_CLEAR0:
            begin
                kind = isadma_pkg::KIND_CLEAR;
            end
            isadma_pkg::PORT_CLEAR1:
            begin
                kind = isadma_pkg::KIND_CLEAR;
                ctl  = 1'b1;
            end
            default:
            begin
                if (page_hit.hit)
                begin
                    kind = isadma_pkg::KIND_PAGE;
                    ch   = page_hit.chan;
                    ctl  = page_hit.chan[2];
                end
            end
        endcase
        if ((kind == isadma_pkg::KIND_MASK || kind == isadma_pkg::KIND_MODE)
            && s1_action_reg == isadma_pkg::ACTION_WRITE)
        begin
            ch = {ctl, s1_wdata_reg[1:0]};
        end
        else if (kind == isadma_pkg::KIND_MASK || kind == isadma_pkg::KIND_MODE
                 || kind == isadma_pkg::KIND_CLEAR)
        begin
            ch = {ctl, 2'b00};
        end
    end

    // Apply the access to the selected channel.
    always_comb
    begin
        rd          = (s1_action_reg == isadma_pkg::ACTION_READ);
        ptr         = ptr_reg[ctl];
        word_cur    = is_count ? count_reg[ch] : base_reg[ch];
        word_new    = ptr ? {s1_wdata_reg, word_cur[7:0]} : {word_cur[15:8], s1_wdata_reg};
        base_next   = base_reg[ch];
        count_next  = count_reg[ch];
        page_next   = page_reg[ch];
        mode_next   = mode_reg[ch];
        masked_next = masked_reg[ch];
        ptr_next    = ptr;
        rdata       = '0;
        case (kind)
            isadma_pkg::KIND_WORD:
            begin
                rdata    = ptr ? word_cur[15:8] : word_cur[7:0];
                ptr_next = !ptr;
                if (!rd)
                begin
                    if (is_count)
                    begin
                        count_next = word_new;
                    end
                    else
                    begin
                        base_next = word_new;
                    end
                end
            end
            isadma_pkg::KIND_MASK:
            begin
                if (!rd)
                begin
                    masked_next = s1_wdata_reg[2];
                end
            end
            isadma_pkg::KIND_MODE:
            begin
                if (!rd)
                begin
                    mode_next = s1_wdata_reg;
                end
            end
            isadma_pkg::KIND_CLEAR:
            begin
                if (!rd)
                begin
                    ptr_next = 1'b0;
                end
            end
            isadma_pkg::KIND_PAGE:
            begin
                rdata = page_reg[ch];
                if (!rd)
                begin
                    page_next = s1_wdata_reg;
                end
            end
            default:
            begin
                rdata = '0;
            end
        endcase
        if (!rd)
        begin
            rdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < isadma_pkg::NumChan; i++)
            begin
                base_reg[i]   <= '0;
                count_reg[i]  <= '0;
                page_reg[i]   <= '0;
                mode_reg[i]   <= '0;
                masked_reg[i] <= 1'b1;
            end
            for (int j = 0; j < isadma_pkg::NumCtl; j++)
            begin
                ptr_reg[j] <= 1'b0;
            end
        end
        else if (fire)
        begin
            base_reg[ch]   <= base_next;
            count_reg[ch]  <= count_next;
            page_reg[ch]   <= page_next;
            mode_reg[ch]   <= mode_next;
            masked_reg[ch] <= masked_next;
            ptr_reg[ctl]   <= ptr_next;
        end
    end

    // Hold the result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (kind == isadma_pkg::KIND_NONE)
            begin
                out_rdata_reg   <= '0;
                out_decoded_reg <= 1'b0;
                out_channel_reg <= '0;
                out_address_reg <= '0;
                out_count_reg   <= '0;
                out_mode_reg    <= '0;
                out_masked_reg  <= 1'b0;
                out_ptr_reg     <= 1'b0;
            end
            else
            begin
                out_rdata_reg   <= rdata;
                out_decoded_reg <= 1'b1;
                out_channel_reg <= ch;
                out_address_reg <= {page_next, base_next};
                out_count_reg   <= count_next;
                out_mode_reg    <= mode_next;
                out_masked_reg  <= masked_next;
                out_ptr_reg     <= ptr_next;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.rdata        = out_rdata_reg;
    assign rsp.decoded      = out_decoded_reg;
    assign rsp.channel      = out_channel_reg;
    assign rsp.chan_address = out_address_reg;
    assign rsp.chan_count   = out_count_reg;
    assign rsp.chan_mode    = out_mode_reg;
    assign rsp.chan_masked  = out_masked_reg;
    assign rsp.pointer_high = out_ptr_reg;

endmodule

// File: rtl/isadma_checker.sv
// Port-level checks of the ISA DMA register file and their bind to the top level.
module isadma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [7:0]  rsp_rdata,
    input logic        rsp_decoded,
    input logic [2:0]  rsp_channel,
    input logic [23:0] rsp_chan_address,
    input logic [15:0] rsp_chan_count,
    input logic [7:0]  rsp_chan_mode,
    input logic        rsp_chan_masked,
    input logic        rsp_pointer_high
);

    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("result valid during reset");

    a_hold_stalled_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata)
            && $stable(rsp_channel) && $stable(rsp_chan_address))
        else $error("stalled result changed");

    a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("access refused while result side drains");

    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_decoded |-> rsp_rdata == 8'h00 && rsp_channel == 3'd0
            && rsp_chan_address == 24'h0 && rsp_chan_count == 16'h0
            && rsp_chan_mode == 8'h00 && !rsp_chan_masked && !rsp_pointer_high)
        else $error("unmapped access returned nonzero fields");

endmodule

bind isa_dma_register_file_core isadma_checker u_isadma_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_rdata        (rsp.rdata),
    .rsp_decoded      (rsp.decoded),
    .rsp_channel      (rsp.channel),
    .rsp_chan_address (rsp.chan_address),
    .rsp_chan_count   (rsp.chan_count),
    .rsp_chan_mode    (rsp.chan_mode),
    .rsp_chan_masked  (rsp.chan_masked),
    .rsp_pointer_high (rsp.pointer_high)
);
